// ===== sv/kv_request_deframer_defines.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef KV_REQUEST_DEFRAMER_DEFINES_SVH
`define KV_REQUEST_DEFRAMER_DEFINES_SVH

// Consequent checked on the same edge as the antecedent.
`define KVD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kvd assertion failed (same cycle)");

// Consequent checked on the edge after the antecedent.
`define KVD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kvd assertion failed (next cycle)");

`endif

// ===== sv/kvd_pkg.sv =====
// Types and constants for the key-value request deframer.
`default_nettype none

package kvd_pkg;

  // Command bytes
  localparam logic [7:0] CMD_PUT   = 8'd11;
  localparam logic [7:0] CMD_DEL   = 8'd12;
  localparam logic [7:0] CMD_GET   = 8'd13;
  localparam logic [7:0] CMD_STATS = 8'd21;

  // Reply bytes
  localparam logic [7:0] REPLY_OK       = 8'd101;
  localparam logic [7:0] REPLY_NOTFOUND = 8'd112;

  // Result kinds
  localparam logic [2:0] KIND_CMD  = 3'd0;
  localparam logic [2:0] KIND_KLEN = 3'd1;
  localparam logic [2:0] KIND_KEY  = 3'd2;
  localparam logic [2:0] KIND_VLEN = 3'd3;
  localparam logic [2:0] KIND_VAL  = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [31:0] length;
    logic        field_last;
    logic        request_done;
    logic        reply_valid;
    logic [7:0]  reply_byte;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/kv_request_deframer.sv =====
// Top level of the key-value request deframer.
// Usage:
//  - Input channel: one request-stream byte per transfer on in_byte, qualified by
//    in_valid; the block raises in_stall to hold the sender off.
//  - Output channel: zero or one result per input byte (command, key length, key
//    byte, value length, value byte), with field_last, request_done and the
//    one-byte reply code; out_valid qualifies it, the receiver raises out_stall.
//  - Length bytes other than the last give no result; everything else gives one.
//  - Each result is registered: into the output register, else into the skid entry.
//  - Throughput: one byte per cycle unless in_stall is high; the stage update is a
//    single 32-bit increment and compare between the state registers.
//  - A result waiting in the output register does not block intake: a skid
//    entry absorbs one more result, and in_stall rises only once that skid
//    entry is occupied (two results held while out_stall is high).
//  - Reset (rst, synchronous, active high) returns the parser to the command
//    stage, clears lengths and counters and empties both output entries.
//  - LEN_BYTES sets the size of each big-endian length; only the low 32 bits
//    of a longer length are kept.
`default_nettype none

module kv_request_deframer #(
  parameter int unsigned LEN_BYTES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_byte,
  output logic [31:0]      out_length,
  output logic             field_last,
  output logic             request_done,
  output logic             reply_valid,
  output logic [7:0]       reply_byte
);

  logic          accept;
  logic          res_valid;
  kvd_pkg::res_t res;
  kvd_pkg::res_t out_res;
  logic          buf_full;

  // input transfer completes when the skid entry is free
  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  kvd_parse #(
    .LEN_BYTES (LEN_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  kvd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_res  (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind     = out_res.kind;
  assign out_byte     = out_res.data;
  assign out_length   = out_res.length;
  assign field_last   = out_res.field_last;
  assign request_done = out_res.request_done;
  assign reply_valid  = out_res.reply_valid;
  assign reply_byte   = out_res.reply_byte;

endmodule

`default_nettype wire

// ===== sv/kvd_parse.sv =====
// Request field tracker: per-byte stage update and result formation.
`default_nettype none
`include "kv_request_deframer_defines.svh"

module kvd_parse #(
  parameter int unsigned LEN_BYTES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  in_byte,
  output logic             res_valid,
  output kvd_pkg::res_t    res
);

  localparam logic [2:0] ST_CMD  = 3'd0;
  localparam logic [2:0] ST_KLEN = 3'd1;
  localparam logic [2:0] ST_KEY  = 3'd2;
  localparam logic [2:0] ST_VLEN = 3'd3;
  localparam logic [2:0] ST_VAL  = 3'd4;

  localparam logic [31:0] LEN_COUNT = 32'(LEN_BYTES);

  logic [2:0]  stage, stage_next;
  logic [7:0]  held_command, held_command_next;
  logic [31:0] length_shift, length_shift_next;
  logic [31:0] byte_index, byte_index_next;
  logic [31:0] field_length, field_length_next;

  logic [31:0] idx_inc;
  logic [31:0] shift_in;
  logic        finish;
  logic        is_key;

  assign idx_inc  = byte_index + 32'd1;
  assign shift_in = {length_shift[23:0], in_byte};

  always_comb begin
    stage_next        = stage;
    held_command_next = held_command;
    length_shift_next = length_shift;
    byte_index_next   = byte_index;
    field_length_next = field_length;
    res_valid         = 1'b0;
    res               = '0;
    finish            = 1'b0;
    is_key            = (stage == ST_KLEN) || (stage == ST_KEY);

    if (accept) begin
      unique case (stage)
        ST_KLEN, ST_VLEN: begin
          length_shift_next = shift_in;
          byte_index_next   = idx_inc;
          if (idx_inc >= LEN_COUNT) begin
            field_length_next = shift_in;
            length_shift_next = '0;
            byte_index_next   = '0;
            res_valid         = 1'b1;
            res.kind          = is_key ? kvd_pkg::KIND_KLEN : kvd_pkg::KIND_VLEN;
            res.length        = shift_in;
            if (shift_in != 32'd0) begin
              stage_next = is_key ? ST_KEY : ST_VAL;
            end else begin
              res.field_last = 1'b1;
              if (is_key && held_command == kvd_pkg::CMD_PUT) begin
                stage_next = ST_VLEN;
              end else begin
                finish = 1'b1;
              end
            end
          end
        end
        ST_KEY, ST_VAL: begin
          res_valid       = 1'b1;
          res.kind        = is_key ? kvd_pkg::KIND_KEY : kvd_pkg::KIND_VAL;
          res.data        = in_byte;
          byte_index_next = idx_inc;
          if (idx_inc >= field_length) begin
            res.field_last  = 1'b1;
            byte_index_next = '0;
            if (is_key && held_command == kvd_pkg::CMD_PUT) begin
              stage_next = ST_VLEN;
            end else begin
              finish = 1'b1;
            end
          end
        end
        default: begin
          // command stage; unused codes land here too
          held_command_next = in_byte;
          res_valid         = 1'b1;
          res.kind          = kvd_pkg::KIND_CMD;
          res.data          = in_byte;
          byte_index_next   = '0;
          length_shift_next = '0;
          if (in_byte == kvd_pkg::CMD_STATS) begin
            finish = 1'b1;
          end else begin
            stage_next = ST_KLEN;
          end
        end
      endcase

      if (finish) begin
        res.request_done  = 1'b1;
        stage_next        = ST_CMD;
        byte_index_next   = '0;
        length_shift_next = '0;
        if (held_command_next == kvd_pkg::CMD_PUT ||
            held_command_next == kvd_pkg::CMD_DEL) begin
          res.reply_valid = 1'b1;
          res.reply_byte  = kvd_pkg::REPLY_OK;
        end else if (held_command_next == kvd_pkg::CMD_GET) begin
          res.reply_valid = 1'b1;
          res.reply_byte  = kvd_pkg::REPLY_NOTFOUND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage        <= ST_CMD;
      held_command <= '0;
      length_shift <= '0;
      byte_index   <= '0;
      field_length <= '0;
    end else begin
      stage        <= stage_next;
      held_command <= held_command_next;
      length_shift <= length_shift_next;
      byte_index   <= byte_index_next;
      field_length <= field_length_next;
    end
  end

  `KVD_ASSERT_NEXT(a_done_to_cmd, clk, rst, accept && res.request_done, stage == ST_CMD)
  `KVD_ASSERT_NEXT(a_cmd_to_klen, clk, rst,
    accept && stage == ST_CMD && in_byte != kvd_pkg::CMD_STATS, stage == ST_KLEN)
  `KVD_ASSERT_SAME(a_len_count, clk, rst,
    stage == ST_KLEN || stage == ST_VLEN, byte_index < LEN_COUNT)

endmodule

`default_nettype wire

// ===== sv/kvd_out_reg.sv =====
// Two-entry result buffer: output register plus skid stage.
`default_nettype none
`include "kv_request_deframer_defines.svh"

module kvd_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire kvd_pkg::res_t push_res,
  output logic               full,
  output logic               out_valid,
  input  wire logic          out_stall,
  output kvd_pkg::res_t      out_res
);

  logic          main_valid;
  logic          skid_valid;
  kvd_pkg::res_t main_res;
  kvd_pkg::res_t skid_res;
  logic          pop;

  assign pop       = main_valid && !out_stall;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_res   = main_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_res <= skid_res;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_res <= push_res;
      end else begin
        skid_res <= push_res;
      end
    end
  end

  `KVD_ASSERT_SAME(a_skid_needs_main, clk, rst, skid_valid, main_valid)
  `KVD_ASSERT_NEXT(a_skid_drains, clk, rst, skid_valid && !out_stall,
    main_valid && !skid_valid)
  `KVD_ASSERT_NEXT(a_skid_fills, clk, rst,
    push && main_valid && out_stall && !skid_valid, skid_valid)

endmodule

`default_nettype wire
